// ===== sv/hrd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hrd_pkg
// Shared constants and types for the HTTP redirect detector: status line
// and header patterns, counter widths and the matcher control struct.
// ---------------------------------------------------------------------------
package hrd_pkg;

  localparam int StatusLen = 13;
  localparam int HdrLen    = 19;
  localparam int PosW      = $clog2(StatusLen + 1);
  localparam int ProgW     = $clog2(HdrLen + 1);

  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  typedef logic [7:0] byte_t;
  typedef byte_t status_pat_t [StatusLen];
  typedef byte_t hdr_pat_t [HdrLen];

  localparam status_pat_t StatusV10 = '{
    "H", "T", "T", "P", "/", "1", ".", "0", " ", "3", "0", "2", " "
  };
  localparam status_pat_t StatusV11 = '{
    "H", "T", "T", "P", "/", "1", ".", "1", " ", "3", "0", "2", " "
  };
  localparam hdr_pat_t HdrLocation = '{
    ChCr, ChLf, "L", "o", "c", "a", "t", "i", "o", "n", ":", " ",
    "h", "t", "t", "p", ":", "/", "/"
  };
  localparam hdr_pat_t HdrClose = '{
    ChCr, ChLf, "C", "o", "n", "n", "e", "c", "t", "i", "o", "n", ":",
    " ", "c", "l", "o", "s", "e"
  };

  typedef struct packed {
    logic step;
    logic clear;
  } match_ctl_t;

endpackage

// ===== sv/hrd_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hrd_if
// Valid/ready channels: payload byte words in, verdict words out.
// ---------------------------------------------------------------------------
interface hrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hrd_out_if;
  logic valid;
  logic ready;
  logic is_redirect;
  logic status_matched;
  logic location_seen;
  logic close_seen;

  modport source (output valid, output is_redirect, output status_matched,
                  output location_seen, output close_seen, input ready);
  modport sink   (input valid, input is_redirect, input status_matched,
                  input location_seen, input close_seen, output ready);
endinterface

// ===== sv/hrd_matcher.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hrd_matcher
// Fixed-string search over a byte stream. Tracks matched length and a sticky
// found flag; clears on the last byte of a payload.
// ---------------------------------------------------------------------------
module hrd_matcher (
  input  logic               clk,
  input  logic               rst_n,
  input  hrd_pkg::hdr_pat_t  pat,
  input  hrd_pkg::match_ctl_t ctl,
  input  hrd_pkg::byte_t     data_byte,
  output logic               found
);
  import hrd_pkg::*;

  logic [ProgW-1:0] prog_r, prog_nxt;
  logic             found_r, found_nxt;
  logic [ProgW-1:0] adv;
  logic             hit;

  always_comb begin
    if ((prog_r < ProgW'(HdrLen)) && (pat[prog_r] == data_byte)) begin
      adv = prog_r + ProgW'(1);
    end else if (data_byte == ChCr) begin
      adv = ProgW'(1);
    end else begin
      adv = '0;
    end
  end

  assign hit   = !found_r && (adv == ProgW'(HdrLen));
  assign found = found_r | hit;

  always_comb begin
    prog_nxt  = prog_r;
    found_nxt = found_r;
    if (ctl.step) begin
      if (ctl.clear) begin
        prog_nxt  = '0;
        found_nxt = 1'b0;
      end else if (!found_r) begin
        prog_nxt  = hit ? '0 : adv;
        found_nxt = hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_r  <= '0;
      found_r <= 1'b0;
    end else begin
      prog_r  <= prog_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

// ===== sv/http_redirect_detector_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// http_redirect_detector_top
// Judges whether a TCP payload is a plain-http 302 redirect that closes
// the connection.
//
// in_ch carries one payload byte per word, last_byte marking the final one.
// out_ch carries one verdict word per payload, for its last byte only:
// is_redirect, status_matched, location_seen, close_seen.
// A byte word is taken into an input register; from there it updates the
// status-line check and both header matchers and, on a last byte, loads the
// output register. Throughput is one byte per cycle unless a last byte
// stalls.
// The output register lets the input keep flowing while a verdict waits;
// only a last byte stalls, in the input register, while an earlier verdict
// is still untaken, and in_ch.ready then drops.
// Reset (rst_n low, synchronous) empties both registers and returns all
// match state to the start of a payload. After each last byte the state
// returns to the same start values.
// ---------------------------------------------------------------------------
module http_redirect_detector_top (
  input logic      clk,
  input logic      rst_n,
  hrd_in_if.sink   in_ch,
  hrd_out_if.source out_ch
);
  import hrd_pkg::*;

  logic            s1_valid_r;
  byte_t           s1_byte_r;
  logic            s1_last_r;
  logic            s1_go;
  logic            out_free;

  logic [PosW-1:0] pos_r, pos_nxt;
  logic            ok11_r, ok11_nxt;
  logic            ok10_r, ok10_nxt;
  logic            status_hit;

  match_ctl_t      mctl;
  logic            loc_found;
  logic            cls_found;

  logic            out_valid_r;
  logic            out_redirect_r;
  logic            out_status_r;
  logic            out_loc_r;
  logic            out_cls_r;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_go       = s1_valid_r && (!s1_last_r || out_free);
  assign in_ch.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last_byte;
    end
  end

  // status line check over the first bytes
  always_comb begin
    pos_nxt  = pos_r;
    ok11_nxt = ok11_r;
    ok10_nxt = ok10_r;
    if (pos_r < PosW'(StatusLen)) begin
      if (s1_byte_r != StatusV11[pos_r]) ok11_nxt = 1'b0;
      if (s1_byte_r != StatusV10[pos_r]) ok10_nxt = 1'b0;
      pos_nxt = pos_r + PosW'(1);
    end
  end

  assign status_hit = (pos_nxt == PosW'(StatusLen)) && (ok11_nxt || ok10_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      ok11_r <= 1'b1;
      ok10_r <= 1'b1;
    end else if (s1_go) begin
      if (s1_last_r) begin
        pos_r  <= '0;
        ok11_r <= 1'b1;
        ok10_r <= 1'b1;
      end else begin
        pos_r  <= pos_nxt;
        ok11_r <= ok11_nxt;
        ok10_r <= ok10_nxt;
      end
    end
  end

  assign mctl.step  = s1_go;
  assign mctl.clear = s1_last_r;

  hrd_matcher u_loc (
    .clk       (clk),
    .rst_n     (rst_n),
    .pat       (HdrLocation),
    .ctl       (mctl),
    .data_byte (s1_byte_r),
    .found     (loc_found)
  );

  hrd_matcher u_cls (
    .clk       (clk),
    .rst_n     (rst_n),
    .pat       (HdrClose),
    .ctl       (mctl),
    .data_byte (s1_byte_r),
    .found     (cls_found)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_redirect_r <= status_hit && loc_found && cls_found;
      out_status_r   <= status_hit;
      out_loc_r      <= loc_found;
      out_cls_r      <= cls_found;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.is_redirect    = out_redirect_r;
  assign out_ch.status_matched = out_status_r;
  assign out_ch.location_seen  = out_loc_r;
  assign out_ch.close_seen     = out_cls_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PosW'(StatusLen))
    else $error("status position beyond status line");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_last_r |=> pos_r == '0 && ok11_r && ok10_r)
    else $error("status check not restarted after last byte");

  a_verdict_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_last_r))
    else $error("verdict without a last byte");

  a_verdict_and: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_redirect_r == (out_status_r && out_loc_r && out_cls_r))
    else $error("redirect verdict disagrees with findings");

endmodule

// ===== verif/hrd_verdict_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hrd_verdict_checker
// Watches both channels of the HTTP redirect detector. It tracks the status
// line check and both header searches for each accepted byte word, queues
// the expected verdict on a last byte, and compares each accepted verdict
// word, field by field, with the oldest one queued.
// ---------------------------------------------------------------------------
module hrd_verdict_checker (
  input  logic clk,
  input  logic rst_n,
  hrd_in_if    in_ch,
  hrd_out_if   out_ch,
  output int   fail_count,
  output int   verdicts_pending
);
  import hrd_pkg::*;

  typedef struct packed {
    logic is_redirect;
    logic status_matched;
    logic location_seen;
    logic close_seen;
  } verdict_t;

  logic [PosW-1:0]  byte_pos;
  logic             v11_ok;
  logic             v10_ok;
  logic [ProgW-1:0] loc_len;
  logic [ProgW-1:0] cls_len;
  logic             loc_hit;
  logic             cls_hit;
  verdict_t         verdict_q[$];
  int               fail_total = 0;
  int               pending    = 0;

  assign fail_count       = fail_total;
  assign verdicts_pending = pending;

  task automatic report_mismatch(input string msg);
    $display("[%0t] verdict mismatch: %s", $time, msg);
    fail_total++;
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want)
      report_mismatch($sformatf("%s got %b, expected %b", name, got, want));
  endtask

  task automatic restart_payload();
    byte_pos = '0;
    v11_ok   = 1'b1;
    v10_ok   = 1'b1;
    loc_len  = '0;
    cls_len  = '0;
    loc_hit  = 1'b0;
    cls_hit  = 1'b0;
  endtask

  // CR only opens either header, so a mismatch restarts at 1 on CR, else 0
  function automatic logic [ProgW-1:0] next_hdr_len(input hdr_pat_t pat,
                                                   input logic [ProgW-1:0] len,
                                                   input byte_t b);
    if (len < HdrLen && pat[len] == b) return len + 1'b1;
    return (b == ChCr) ? ProgW'(1) : '0;
  endfunction

  always @(posedge clk) begin
    byte_t    b;
    verdict_t want;
    if (!rst_n) begin
      restart_payload();
      verdict_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict word with no payload outstanding");
        end else begin
          want = verdict_q.pop_front();
          check_field("is_redirect", out_ch.is_redirect, want.is_redirect);
          check_field("status_matched", out_ch.status_matched, want.status_matched);
          check_field("location_seen", out_ch.location_seen, want.location_seen);
          check_field("close_seen", out_ch.close_seen, want.close_seen);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        b = in_ch.data_byte;
        if (byte_pos < StatusLen) begin
          if (b != StatusV11[byte_pos]) v11_ok = 1'b0;
          if (b != StatusV10[byte_pos]) v10_ok = 1'b0;
          byte_pos = byte_pos + 1'b1;
        end
        if (!loc_hit) begin
          loc_len = next_hdr_len(HdrLocation, loc_len, b);
          if (loc_len >= HdrLen) begin
            loc_hit = 1'b1;
            loc_len = '0;
          end
        end
        if (!cls_hit) begin
          cls_len = next_hdr_len(HdrClose, cls_len, b);
          if (cls_len >= HdrLen) begin
            cls_hit = 1'b1;
            cls_len = '0;
          end
        end
        if (in_ch.last_byte) begin
          want.status_matched = (byte_pos >= StatusLen) && (v11_ok || v10_ok);
          want.location_seen  = loc_hit;
          want.close_seen     = cls_hit;
          want.is_redirect    = want.status_matched && loc_hit && cls_hit;
          verdict_q.push_back(want);
          restart_payload();
        end
      end
    end
    pending <= verdict_q.size();
  end

endmodule

// ===== verif/tb_http_redirect_detector_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_http_redirect_detector_top
// Streams payloads through the redirect detector: a few directed short
// payloads, then random ones built from status lines, whole and broken
// header strings, CR/LF filler and raw noise. Both sides idle at random and
// the result side holds off once for a long stretch to fill the block.
// ---------------------------------------------------------------------------
module tb_http_redirect_detector_top;
  import hrd_pkg::*;

  localparam int ClkPeriod     = 20;
  localparam int ByteTarget    = 550;
  localparam int CalmFrom      = ByteTarget * 85 / 100;
  localparam int HoldCycles    = 150;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 6;

  logic  clk = 1'b0;
  logic  rst_n;
  int    fail_count;
  int    verdicts_pending;
  int    bytes_sent    = 0;
  int    payloads_sent = 0;
  int    quiet_cycles  = 0;
  bit    idle_en       = 1'b1;
  bit    src_calm      = 1'b0;
  bit    hold_req      = 1'b0;
  bit    hold_active   = 1'b0;
  byte_t pkt[$];

  hrd_in_if  in_ch();
  hrd_out_if out_ch();

  http_redirect_detector_top u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  hrd_verdict_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .verdicts_pending(verdicts_pending)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("http_redirect_detector_top regression: fail");
        $finish;
      end
    end
  end

  function automatic byte_t filler_byte();
    case ($urandom_range(0, 9))
      0, 1:    return ChCr;
      2:       return ChLf;
      default: return byte_t'($urandom_range(8'h20, 8'h7E));
    endcase
  endfunction

  task automatic append_filler(input int n);
    repeat (n) pkt.push_back(filler_byte());
  endtask

  task automatic append_hdr(input hdr_pat_t pat, input int len);
    for (int i = 0; i < len; i++) pkt.push_back(pat[i]);
  endtask

  task automatic send_word(input byte_t b, input logic last);
    if (idle_en && !src_calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_payload();
    foreach (pkt[i]) send_word(pkt[i], i == pkt.size() - 1);
    payloads_sent++;
    pkt.delete();
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_active = 1'b0;
      end else if (idle_en && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      if (idle_en && $urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) @(posedge clk);
      else repeat ($urandom_range(20, 60)) @(posedge clk);
    end
  end

  initial begin
    bit v11;
    bit hold_done;
    int len;
    hold_done = 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    out_ch.ready    <= 1'b0;
    rst_n           <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // one-byte payloads at the byte extremes and a lone CR
    pkt.push_back(8'h00);
    send_payload();
    pkt.push_back(8'hFF);
    send_payload();
    pkt.push_back(ChCr);
    send_payload();
    // CR CR LF: header search restarts on the second CR
    pkt.push_back(ChCr);
    pkt.push_back(ChCr);
    pkt.push_back(ChLf);
    pkt.push_back("C");
    send_payload();
    // status line one byte short
    for (int i = 0; i < StatusLen - 1; i++) pkt.push_back(StatusV11[i]);
    send_payload();

    while (bytes_sent < ByteTarget) begin
      if (bytes_sent >= CalmFrom) idle_en = 1'b0;
      src_calm = ($urandom_range(0, 2) == 0);
      v11      = $urandom_range(0, 1);

      if (!hold_done && bytes_sent >= ByteTarget / 3) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (!hold_active);
        repeat (8) begin
          pkt.push_back(byte_t'($urandom_range(0, 255)));
          send_payload();
        end
      end

      case ($urandom_range(0, 9))
        0, 1, 2: begin
          for (int i = 0; i < StatusLen; i++)
            pkt.push_back(v11 ? StatusV11[i] : StatusV10[i]);
          if ($urandom_range(0, 5) == 0)
            pkt[$urandom_range(0, StatusLen - 1)] = byte_t'($urandom_range(0, 255));
          if ($urandom_range(0, 5) != 0) begin
            repeat ($urandom_range(2, 5)) begin
              case ($urandom_range(0, 7))
                0, 1: append_hdr(HdrLocation, HdrLen);
                2, 3: append_hdr(HdrClose, HdrLen);
                4: begin
                  append_hdr(HdrLocation, $urandom_range(1, HdrLen - 1));
                  append_filler(1);
                end
                5: begin
                  append_hdr(HdrClose, $urandom_range(1, HdrLen - 1));
                  append_filler(1);
                end
                6: append_filler($urandom_range(1, 6));
                default: begin
                  pkt.push_back(ChCr);
                  append_hdr(HdrLocation, HdrLen);
                end
              endcase
              append_filler($urandom_range(0, 2));
            end
          end
        end
        3, 4, 5, 6: begin
          len = $urandom_range(1, StatusLen + 1);
          for (int i = 0; i < len; i++)
            pkt.push_back((i < StatusLen && $urandom_range(0, 4) != 0) ?
                          (v11 ? StatusV11[i] : StatusV10[i]) : filler_byte());
        end
        default: begin
          len = $urandom_range(1, 24);
          repeat (len) pkt.push_back(byte_t'($urandom_range(0, 255)));
        end
      endcase
      send_payload();
    end

    idle_en = 1'b0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("http_redirect_detector_top regression: pass");
    end else begin
      $display("http_redirect_detector_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/hrd_pkg.sv
sv/hrd_if.sv
sv/hrd_matcher.sv
sv/http_redirect_detector_top.sv
verif/hrd_verdict_checker.sv
verif/tb_http_redirect_detector_top.sv
